// ----- sv/led_matrix_row_scanner_assert.svh -----
// Assertion macros for the LED matrix row scanner.
`ifndef LED_MATRIX_ROW_SCANNER_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LMRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lmrs_pkg.sv -----
`default_nettype none

package lmrs_pkg;

	localparam int unsigned ROW_COUNT = 8;
	localparam int unsigned ROW_W     = 3;
	localparam int unsigned POS_W     = 4;

	localparam logic [7:0]       TOP_BIT  = 8'h80;
	localparam logic [POS_W-1:0] LAST_POS = 4'd15;

	// Item kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [ROW_W-1:0] row_index;
		logic [7:0]       row_bits;
	} item_t;

	typedef struct packed {
		logic             serial_bit;
		logic [POS_W-1:0] bit_position;
		logic             latch_after;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHIFT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic write_row;
		logic start_tick;
		logic emit_bit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic last_bit;
	} status_t;

endpackage

`default_nettype wire

// ----- sv/lmrs_ctrl.sv -----
`default_nettype none

module lmrs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_action,
	output logic                   item_stall,
	input  wire lmrs_pkg::status_t status,
	output lmrs_pkg::cmd_t         cmd
);

	lmrs_pkg::state_t state_q;
	lmrs_pkg::state_t state_next;
	logic             accept;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Outputs
	always_comb begin
		item_stall     = (state_q != lmrs_pkg::ST_IDLE);
		accept         = item_valid && !item_stall;
		cmd.write_row  = accept && (item_action == lmrs_pkg::ACT_WRITE);
		cmd.start_tick = accept && (item_action == lmrs_pkg::ACT_TICK);
		cmd.emit_bit   = (state_q == lmrs_pkg::ST_SHIFT) && status.slot_free;
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			lmrs_pkg::ST_IDLE: begin
				if (item_valid && (item_action == lmrs_pkg::ACT_TICK)) begin
					state_next = lmrs_pkg::ST_SHIFT;
				end
			end
			lmrs_pkg::ST_SHIFT: begin
				if (status.slot_free && status.last_bit) begin
					state_next = lmrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lmrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/lmrs_datapath.sv -----
`default_nettype none

module lmrs_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lmrs_pkg::item_t   item,
	input  wire lmrs_pkg::cmd_t    cmd,
	output lmrs_pkg::status_t      status,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output lmrs_pkg::result_t      result
);

	logic [7:0]                 frame_q [lmrs_pkg::ROW_COUNT];
	logic [lmrs_pkg::ROW_W-1:0] scan_q;
	logic [lmrs_pkg::ROW_W-1:0] scan_next;
	logic [15:0]                shift_q;
	logic [lmrs_pkg::POS_W-1:0] pos_q;
	logic                       valid_q;
	lmrs_pkg::result_t          result_q;

	assign scan_next = scan_q + 1'b1;

	// Frame buffer, reset to a diagonal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < lmrs_pkg::ROW_COUNT; r++) begin
				frame_q[r] <= 8'(lmrs_pkg::TOP_BIT >> r);
			end
		end else if (cmd.write_row) begin
			frame_q[item.row_index] <= item.row_bits;
		end
	end

	// Scan counter, advanced before each scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.start_tick) begin
			scan_q <= scan_next;
		end
	end

	// Serializer: row byte then one-hot row select, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.start_tick) begin
			pos_q <= '0;
		end else if (cmd.emit_bit) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_tick) begin
			shift_q <= {frame_q[scan_next], lmrs_pkg::TOP_BIT >> scan_next};
		end else if (cmd.emit_bit) begin
			shift_q <= {shift_q[14:0], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_bit) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bit) begin
			result_q.serial_bit   <= shift_q[15];
			result_q.bit_position <= pos_q;
			result_q.latch_after  <= (pos_q == lmrs_pkg::LAST_POS);
		end
	end

	assign status.slot_free = !valid_q || !result_stall;
	assign status.last_bit  = (pos_q == lmrs_pkg::LAST_POS);
	assign result_valid     = valid_q;
	assign result           = result_q;

endmodule

`default_nettype wire

// ----- sv/led_matrix_row_scanner.sv -----
// LED matrix row scanner.
// Item channel (item_valid / item_stall / item): a write item stores row_bits
// into frame row row_index. A tick item advances the scan row (mod 8) and
// then serializes 16 bits: the row byte MSB first, then a one-hot active-high
// row select, row 0 first; the 16th bit has latch_after set.
// Result channel (result_valid / result_stall / result): one bit per transfer.
// A tick is accepted only in ST_IDLE; each of its bits is emitted in ST_SHIFT
// and registered in the output register, and the bits follow
// one per cycle when the receiver never stalls. The one-bit serializer
// and its position counter set this rate. item_stall is high while a tick is
// being serialized. A stall on the result side holds the output register and
// pauses the serializer; the next item is taken as soon as the last bit is
// registered.
// Reset (arst_n low) loads the frame buffer with a diagonal (row r = 0x80 >> r),
// clears the scan row to 0, and drops result_valid.
`default_nettype none

`include "led_matrix_row_scanner_assert.svh"

module led_matrix_row_scanner (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire lmrs_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output lmrs_pkg::result_t      result
);

	lmrs_pkg::cmd_t    cmd;
	lmrs_pkg::status_t status;

	lmrs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_action (item.action),
		.item_stall  (item_stall),
		.status      (status),
		.cmd         (cmd)
	);

	lmrs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Checks
	`LMRS_ASSERT_NEXT(a_tick_busy, clk, arst_n, cmd.start_tick, item_stall,
		"item channel open right after a tick transfer")
	`LMRS_ASSERT_SAME(a_emit_busy, clk, arst_n, cmd.emit_bit, item_stall,
		"bit emitted while item channel open")
	`LMRS_ASSERT_NEXT(a_last_latch, clk, arst_n, cmd.emit_bit && status.last_bit,
		result_valid && result.latch_after && (result.bit_position == lmrs_pkg::LAST_POS),
		"last serial bit not marked for latch")

endmodule

`default_nettype wire
